FILE: hw/rtl/ssds_pkg.sv
// Shared types and constants of the stepper slot dispense sequencer.
`default_nettype none
package ssds_pkg;

   localparam int SUM_W       = 18;
   localparam int RUN_W       = 16;
   localparam int COUNT_W     = 8;
   localparam int ROUND_W     = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
   localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Command codes
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_CALIB    = 2'd1;
   localparam logic [1:0] OP_DISPENSE = 2'd2;
   localparam logic [1:0] OP_FACTORY  = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_CAL  = 2'd1;
   localparam logic [1:0] ST_NO_PILL = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TREATMENT_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FALL_TIMEOUT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURN_DIRECTION   = 2'd2;

   typedef enum logic [7:0] {
      PH_IDLE       = 8'b0000_0001,
      PH_SEEK_GAP   = 8'b0000_0010,
      PH_SEEK_BLIND = 8'b0000_0100,
      PH_MEAS_GAP   = 8'b0000_1000,
      PH_MEAS_BLIND = 8'b0001_0000,
      PH_CENTER     = 8'b0010_0000,
      PH_MOVE       = 8'b0100_0000,
      PH_WAIT       = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0] op;
      logic       opto_level;
      logic       pill_seen;
   } req_type;

   typedef struct packed {
      logic              step_pulse;
      logic              step_direction;
      logic              busy_res;
      logic              done_res;
      logic [1:0]        status;
      logic              calibrated;
      logic [COUNT_W-1:0] dispensed_count;
      logic [15:0]       steps_per_turn;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  treatment_period;
      logic [15:0] fall_timeout_ticks;
      logic        turn_direction;
   } cfg_type;

   // Per-tick outcome of the sequencer
   typedef struct packed {
      logic               step;
      logic               busy;
      logic               done;
      logic [1:0]         status;
      logic               calibrated;
      logic [COUNT_W-1:0] count;
   } tick_type;

endpackage
`default_nettype wire

FILE: hw/rtl/stepper_slot_dispense_sequencer_top.sv
// Top level of the stepper slot dispense sequencer.
//
// req_* carries one tick of the stepper timebase: a command, the opto fork
// level and the pill sensor flag. rsp_* returns one item per tick: the step
// pulse and direction plus busy, done, status, calibration flag, pill count
// and averaged steps per revolution. csr_* writes treatment_period (0),
// fall_timeout_ticks (1) and turn_direction (2) at any clock edge with
// csr_we high; write only while no tick is in flight.
// The item of an accepted tick is registered and shows on rsp_* in the cycle
// after it is accepted. Throughput is one tick per cycle while rsp_ready is
// high, set by the single result register behind the per-tick state update.
// req_ready is low only while a result is held and rsp_ready is low; the
// sequence state then holds until the result is taken.
// Reset is synchronous: the sequencer goes idle and uncalibrated, the pill
// count clears, the revolution sum returns to its default of 4096 steps per
// turn and the registers return to 7, 1000 and 0.
`default_nettype none
module stepper_slot_dispense_sequencer_top
   import ssds_pkg::*;
#(
   parameter int ROUNDS = 4,
   parameter int SLOTS  = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type          cfg;
   tick_type         tick;
   logic [SUM_W-1:0] turn_sum;
   logic [15:0]      steps_per_turn;
   logic             accept;

   logic     out_valid_ff, out_valid_in;
   tick_type out_tick_ff;
   logic     out_dir_ff;

   ssds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssds_seq #(
      .ROUNDS (ROUNDS),
      .SLOTS  (SLOTS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .advance  (accept),
      .req      (req_data),
      .cfg      (cfg),
      .tick     (tick),
      .turn_sum (turn_sum)
   );

   // The sum only moves when a new result is loaded, so it matches the held item
   ssds_cdiv #(
      .DIVISOR (ROUNDS),
      .IN_W    (SUM_W),
      .OUT_W   (16)
   ) u_turn_div (
      .dividend (turn_sum),
      .quotient (steps_per_turn)
   );

   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (accept) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_tick_ff <= tick;
         out_dir_ff  <= cfg.turn_direction;
      end
   end

   assign rsp_valid = out_valid_ff;

   always_comb begin
      rsp_data.step_pulse      = out_tick_ff.step;
      rsp_data.step_direction  = out_dir_ff;
      rsp_data.busy_res        = out_tick_ff.busy;
      rsp_data.done_res        = out_tick_ff.done;
      rsp_data.status          = out_tick_ff.status;
      rsp_data.calibrated      = out_tick_ff.calibrated;
      rsp_data.dispensed_count = out_tick_ff.count;
      rsp_data.steps_per_turn  = steps_per_turn;
   end

`ifndef SYNTHESIS
   a_accept_gives_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted tick produced no result");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("sequence reported done while still busy");

   a_step_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.step_pulse |-> rsp_data.busy_res && !rsp_data.done_res)
      else $error("step pulse outside a running sequence");

   a_status_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> rsp_data.status == ST_OK)
      else $error("status set without done");

   a_empty_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |->
         !rsp_data.calibrated && rsp_data.dispensed_count == '0)
      else $error("empty report left calibration or count set");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/ssds_csr.sv
// Configuration registers of the dispense sequencer.
`default_nettype none
module ssds_csr
   import ssds_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TREATMENT_PERIOD: cfg_in.treatment_period   = csr_wdata[7:0];
            CSR_FALL_TIMEOUT:     cfg_in.fall_timeout_ticks = csr_wdata;
            CSR_TURN_DIRECTION:   cfg_in.turn_direction     = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.treatment_period   <= 8'd7;
         cfg_ff.fall_timeout_ticks <= 16'd1000;
         cfg_ff.turn_direction     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/ssds_cdiv.sv
// Division by a constant through a rounded-up reciprocal, exact for every input.
`default_nettype none
module ssds_cdiv #(
   parameter int DIVISOR = 4,
   parameter int IN_W    = 18,
   parameter int OUT_W   = 16
) (
   input  wire logic [IN_W-1:0]  dividend,
   output logic      [OUT_W-1:0] quotient
);

   localparam int SHIFT = IN_W + $clog2(DIVISOR);
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [SHIFT:0] RECIP = RECIP_FULL[SHIFT:0];

   logic [IN_W+SHIFT:0] product;

   assign product  = {{(SHIFT+1){1'b0}}, dividend} * {{IN_W{1'b0}}, RECIP};
   assign quotient = product[SHIFT +: OUT_W];

endmodule
`default_nettype wire

FILE: hw/rtl/ssds_seq.sv
// Calibration and dispense sequencer: phase state and per-tick update.
`default_nettype none
module ssds_seq
   import ssds_pkg::*;
#(
   parameter int ROUNDS = 4,
   parameter int SLOTS  = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output tick_type     tick,
   output logic [SUM_W-1:0] turn_sum
);

   localparam int SLOT_DIV = SLOTS * ROUNDS;
   localparam int SLOT_IN_W = SUM_W + 2;

   phase_type          phase_ff, phase_in, phase_mid;
   logic               cal_ff, cal_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic [RUN_W-1:0]   gap_ff, gap_in;
   logic [RUN_W-1:0]   timer_ff, timer_in;
   logic               latch_ff, latch_in;

   logic [SLOT_IN_W-1:0] slot_dividend;
   logic [RUN_W-1:0]     slot_steps;
   logic [SUM_W:0]       sum_wide;
   logic [RUN_W-1:0]     half_gap;
   logic                 step, done;
   logic [1:0]           status;

   // round(sum / (SLOTS*ROUNDS)) as floor((2*sum + d) / (2*d))
   assign slot_dividend = {1'b0, sum_ff, 1'b0} + SLOT_IN_W'(SLOT_DIV);

   ssds_cdiv #(
      .DIVISOR (2 * SLOT_DIV),
      .IN_W    (SLOT_IN_W),
      .OUT_W   (RUN_W)
   ) u_slot_div (
      .dividend (slot_dividend),
      .quotient (slot_steps)
   );

   assign half_gap = {1'b0, gap_ff[RUN_W-1:1]};

   always_comb begin
      phase_mid = phase_ff;
      cal_in    = cal_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      round_in  = round_ff;
      run_in    = run_ff;
      gap_in    = gap_ff;
      timer_in  = timer_ff;
      latch_in  = latch_ff;
      step      = 1'b0;
      done      = 1'b0;
      status    = ST_OK;
      sum_wide  = {1'b0, sum_ff} + {{(SUM_W+1-RUN_W){1'b0}}, run_ff};

      // Commands are taken only while idle
      if (phase_ff == PH_IDLE) begin
         case (req.op)
            OP_CALIB: phase_mid = PH_SEEK_GAP;
            OP_DISPENSE: begin
               if (!cal_ff) begin
                  done   = 1'b1;
                  status = ST_NO_CAL;
               end else begin
                  latch_in  = 1'b0;
                  run_in    = slot_steps;
                  phase_mid = PH_MOVE;
               end
            end
            OP_FACTORY: begin
               cal_in   = 1'b0;
               count_in = '0;
               done     = 1'b1;
            end
            default: phase_mid = phase_ff;
         endcase
      end

      if (phase_mid == PH_MOVE || phase_mid == PH_WAIT) begin
         latch_in = latch_in | req.pill_seen;
      end

      phase_in = phase_mid;

      // A command taken while idle is acted on by its first phase within the same tick
      case (phase_mid)
         PH_IDLE: phase_in = PH_IDLE;
         PH_SEEK_GAP: begin
            step = 1'b1;
            if (req.opto_level) phase_in = PH_SEEK_BLIND;
         end
         PH_SEEK_BLIND: begin
            step = 1'b1;
            if (!req.opto_level) begin
               sum_in   = '0;
               round_in = '0;
               run_in   = RUN_W'(1);
               phase_in = PH_MEAS_GAP;
            end
         end
         PH_MEAS_GAP: begin
            step   = 1'b1;
            run_in = (run_ff != RUN_MAX) ? run_ff + RUN_W'(1) : RUN_MAX;
            if (req.opto_level) begin
               gap_in   = run_ff;
               phase_in = PH_MEAS_BLIND;
            end
         end
         PH_MEAS_BLIND: begin
            if (req.opto_level) begin
               step   = 1'b1;
               run_in = (run_ff != RUN_MAX) ? run_ff + RUN_W'(1) : RUN_MAX;
            end else begin
               sum_in = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
               if (({1'b0, round_ff} + (ROUND_W+1)'(1)) >= (ROUND_W+1)'(ROUNDS)) begin
                  if (half_gap != '0) begin
                     step     = 1'b1;
                     run_in   = half_gap - RUN_W'(1);
                     phase_in = PH_CENTER;
                  end else begin
                     run_in   = '0;
                     cal_in   = 1'b1;
                     count_in = '0;
                     done     = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end else begin
                  round_in = round_ff + ROUND_W'(1);
                  step     = 1'b1;
                  run_in   = RUN_W'(1);
                  phase_in = PH_MEAS_GAP;
               end
            end
         end
         PH_CENTER: begin
            if (run_ff != '0) begin
               step   = 1'b1;
               run_in = run_ff - RUN_W'(1);
            end else begin
               cal_in   = 1'b1;
               count_in = '0;
               done     = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         PH_MOVE, PH_WAIT: begin
            if (phase_mid == PH_MOVE && run_in != '0) begin
               step   = 1'b1;
               run_in = run_in - RUN_W'(1);
            end else begin
               if (phase_mid == PH_MOVE) timer_in = '0;
               phase_in = PH_WAIT;
               if (latch_in) begin
                  count_in = (count_in != COUNT_MAX) ? count_in + COUNT_W'(1) : count_in;
                  done     = 1'b1;
                  if (count_in >= cfg.treatment_period) begin
                     cal_in   = 1'b0;
                     count_in = '0;
                     status   = ST_EMPTY;
                  end
                  phase_in = PH_IDLE;
               end else begin
                  if (timer_in != RUN_MAX) timer_in = timer_in + RUN_W'(1);
                  if (timer_in >= cfg.fall_timeout_ticks) begin
                     done     = 1'b1;
                     status   = ST_NO_PILL;
                     phase_in = PH_IDLE;
                  end
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cal_ff   <= 1'b0;
         count_ff <= '0;
         sum_ff   <= SUM_W'(4096 * ROUNDS);
         round_ff <= '0;
         run_ff   <= '0;
         gap_ff   <= '0;
         timer_ff <= '0;
         latch_ff <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         cal_ff   <= cal_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         round_ff <= round_in;
         run_ff   <= run_in;
         gap_ff   <= gap_in;
         timer_ff <= timer_in;
         latch_ff <= latch_in;
      end
   end

   always_comb begin
      tick.step       = step;
      tick.busy       = (phase_in != PH_IDLE);
      tick.done       = done;
      tick.status     = status;
      tick.calibrated = cal_in;
      tick.count      = count_in;
   end

   assign turn_sum = sum_ff;

endmodule
`default_nettype wire
